/* hdl/twcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_pkg
// Shared types and constants for the textured wall column drawer.
// ----------------------------------------------------------------------------
package twcd_pkg;

  localparam int TEX_SIZE_DEF      = 64;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int TEXTURE_COUNT_DEF = 6;

  localparam int COLOR_W = 24;
  localparam int ROW_W   = 12;
  localparam int ADDR_W  = 15;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 48;
  localparam int OFF_W   = 18;
  localparam int CHOICE_W = 3;

  localparam logic [COLOR_W-1:0] HALF_MASK = 24'h7F7F7F;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_DRAW  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    HIT_WALL = 2'd0,
    HIT_DOOR = 2'd1,
    HIT_OPEN = 2'd2
  } hit_kind_t;

  typedef enum logic [CHOICE_W-1:0] {
    TEX_NORTH     = 3'd0,
    TEX_SOUTH     = 3'd1,
    TEX_WEST      = 3'd2,
    TEX_EAST      = 3'd3,
    TEX_DOOR      = 3'd4,
    TEX_DOOR_OPEN = 3'd5
  } tex_id_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

/* hdl/twcd_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_alu
// Shared adder/subtractor used for division, multiplication and stepping.
// ----------------------------------------------------------------------------
module twcd_alu #(
  parameter int W = twcd_pkg::POS_W
) (
  input  twcd_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      y
);

  always_comb begin
    case (op)
      twcd_pkg::ALU_SUB: y = a + ~b + W'(1);
      default:           y = a + b;
    endcase
  end

endmodule

/* hdl/twcd_tex_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_tex_mem
// Texture store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twcd_tex_mem #(
  parameter int DEPTH = 24576,
  parameter int AW    = 15
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [twcd_pkg::COLOR_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [twcd_pkg::COLOR_W-1:0] rdata
);

  logic [twcd_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/textured_wall_column_drawer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_wall_column_drawer
// Raycaster wall slice texturing: texel load, column setup and per-row pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   load texel, start column or draw next row. Results leave on the out_
//   channel (out_valid / out_stall), one pixel per draw command while rows
//   of the slice remain.
//   Load texel: the write lands in the texture RAM when the address lies
//   inside the store. Start column: one shared adder runs DW restoring
//   division steps for the vertical step, DW = clog2(TEX_SIZE) + 17, then
//   DW shift-add steps for the start position.
//   Draw row: accept, texture RAM read, output register load; the pixel
//   appears on the out_ port the cycle after the load.
//   in_stall is high while a command is in progress. When the receiver
//   stalls, the pixel holds in the output register and a pending draw waits
//   in its final cycle until the register frees up.
//   Reset clears control and column state but for height_r, rem_r and
//   mcand_r; the texture RAM is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module textured_wall_column_drawer #(
  parameter int TEX_SIZE      = twcd_pkg::TEX_SIZE_DEF,
  parameter int SCREEN_HEIGHT = twcd_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEXTURE_COUNT = twcd_pkg::TEXTURE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [twcd_pkg::ADDR_W-1:0]   in_texel_address,
  input  logic [twcd_pkg::COLOR_W-1:0]  in_texel_color,
  input  logic [1:0]                    in_hit_kind,
  input  logic                          in_hit_vertical_side,
  input  logic                          in_dir_x_negative,
  input  logic                          in_dir_y_positive,
  input  logic [twcd_pkg::FRAC_W-1:0]   in_wall_fraction,
  input  logic [twcd_pkg::FRAC_W-1:0]   in_wall_line_height,
  input  logic [twcd_pkg::ROW_W-1:0]    in_first_row,
  input  logic [twcd_pkg::ROW_W-1:0]    in_end_row,
  input  logic [twcd_pkg::ROW_W-1:0]    in_screen_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [twcd_pkg::ROW_W-1:0]    out_pixel_row,
  output logic [twcd_pkg::ROW_W-1:0]    out_pixel_column,
  output logic [twcd_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_write_pixel,
  output logic                          out_last_row
);

  localparam int TW          = $clog2(TEX_SIZE);
  localparam int STORE_DEPTH = TEXTURE_COUNT * TEX_SIZE * TEX_SIZE;
  localparam int SAW         = $clog2(STORE_DEPTH);
  localparam int DW          = TW + 17;
  localparam int CW          = $clog2(DW);
  localparam int HALF_SCREEN = SCREEN_HEIGHT / 2;
  localparam int PW          = twcd_pkg::POS_W;
  localparam int RW          = twcd_pkg::ROW_W;
  localparam int CLW         = twcd_pkg::COLOR_W;
  localparam logic [DW-1:0] DIVIDEND = DW'(TEX_SIZE) << 16;

  twcd_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [twcd_pkg::FRAC_W-1:0]     height_r, height_nxt;
  logic [twcd_pkg::FRAC_W-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]                   step_r, step_nxt;
  logic [PW-1:0]                   mcand_r, mcand_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [twcd_pkg::CHOICE_W-1:0]   choice_r, choice_nxt;
  logic                            shade_r, shade_nxt;
  logic [TW-1:0]                   texcol_r, texcol_nxt;
  logic [RW-1:0]                   cur_row_r, cur_row_nxt;
  logic [RW-1:0]                   stop_row_r, stop_row_nxt;
  logic [RW-1:0]                   col_latch_r, col_latch_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [RW-1:0]                   out_row_r, out_row_nxt;
  logic [RW-1:0]                   out_col_r, out_col_nxt;
  logic [CLW-1:0]                  out_color_r, out_color_nxt;
  logic                            out_write_r, out_write_nxt;
  logic                            out_last_r, out_last_nxt;

  // Handshake and control
  logic                            in_xfer;
  logic                            rows_left;
  logic                            out_free;
  logic                            cnt_done;

  // Shared unit
  twcd_pkg::alu_op_t               alu_op;
  logic [PW-1:0]                   alu_a;
  logic [PW-1:0]                   alu_b;
  logic [PW-1:0]                   alu_y;

  // Column setup
  logic [twcd_pkg::FRAC_W-1:0]     height_eff;
  logic [twcd_pkg::OFF_W-1:0]      offset;
  logic [31:0]                     col_prod;
  logic [31:0]                     col_raw;
  logic [TW-1:0]                   col_clamped;
  logic                            mirror;
  logic [twcd_pkg::CHOICE_W-1:0]   choice_sel;

  // Division step
  logic [CW-1:0]                   div_idx;
  logic [twcd_pkg::FRAC_W:0]       rem_sh;
  logic                            div_ge;

  // Texture access
  logic [31:0]                     ld_addr32;
  logic                            mem_we;
  logic                            mem_re;
  logic [TW-1:0]                   trow;
  logic [31:0]                     rd_addr32;
  logic [CLW-1:0]                  mem_rdata;
  logic [CLW-1:0]                  shaded;

  assign in_xfer   = in_valid && !in_stall;
  assign rows_left = cur_row_r < stop_row_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_done  = cnt_r == CW'(DW - 1);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twcd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == twcd_pkg::ACT_START) begin
            state_nxt = twcd_pkg::ST_DIV;
          end else if (in_action == twcd_pkg::ACT_DRAW && rows_left) begin
            state_nxt = twcd_pkg::ST_FETCH;
          end
        end
      end
      twcd_pkg::ST_DIV: begin
        if (cnt_done) state_nxt = twcd_pkg::ST_MUL;
      end
      twcd_pkg::ST_MUL: begin
        if (cnt_done) state_nxt = twcd_pkg::ST_IDLE;
      end
      twcd_pkg::ST_FETCH: state_nxt = twcd_pkg::ST_EMIT;
      twcd_pkg::ST_EMIT: begin
        if (out_free) state_nxt = twcd_pkg::ST_IDLE;
      end
      default: state_nxt = twcd_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (shared unit operands, RAM read, input stall)
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    mem_re   = 1'b0;
    alu_op   = twcd_pkg::ALU_ADD;
    alu_a    = pos_r;
    alu_b    = '0;
    case (state_r)
      twcd_pkg::ST_IDLE: in_stall = 1'b0;
      twcd_pkg::ST_DIV: begin
        alu_op = twcd_pkg::ALU_SUB;
        alu_a  = PW'(rem_sh);
        alu_b  = PW'(height_r);
      end
      twcd_pkg::ST_MUL: begin
        alu_b = step_r[cnt_r] ? mcand_r : '0;
      end
      twcd_pkg::ST_FETCH: begin
        mem_re = 1'b1;
        alu_b  = PW'(step_r);
      end
      default: ;
    endcase
  end

  twcd_alu #(.W(PW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // --------------------------------------------------------------------------
  // Column setup terms
  // --------------------------------------------------------------------------
  assign height_eff = (in_wall_line_height == '0) ? twcd_pkg::FRAC_W'(1) : in_wall_line_height;
  assign offset = twcd_pkg::OFF_W'(in_first_row) - twcd_pkg::OFF_W'(HALF_SCREEN)
                + twcd_pkg::OFF_W'(height_eff >> 1);

  assign col_prod    = 32'(in_wall_fraction) * 32'(TEX_SIZE);
  assign col_raw     = col_prod >> 16;
  assign col_clamped = (col_raw > 32'(TEX_SIZE - 1)) ? TW'(TEX_SIZE - 1) : col_raw[TW-1:0];
  assign mirror = (!in_hit_vertical_side && in_dir_x_negative)
               || (in_hit_vertical_side && in_dir_y_positive);

  always_comb begin
    case (in_hit_kind)
      twcd_pkg::HIT_DOOR: choice_sel = twcd_pkg::TEX_DOOR;
      twcd_pkg::HIT_OPEN: choice_sel = twcd_pkg::TEX_DOOR_OPEN;
      default: begin
        if (!in_hit_vertical_side) begin
          choice_sel = in_dir_x_negative ? twcd_pkg::TEX_WEST : twcd_pkg::TEX_EAST;
        end else begin
          choice_sel = in_dir_y_positive ? twcd_pkg::TEX_SOUTH : twcd_pkg::TEX_NORTH;
        end
      end
    endcase
  end

  // Restoring division: bring down one dividend bit per step
  assign div_idx = CW'(DW - 1) - cnt_r;
  assign rem_sh  = {rem_r, DIVIDEND[div_idx]};
  assign div_ge  = !alu_y[PW-1];

  // --------------------------------------------------------------------------
  // Texture access
  // --------------------------------------------------------------------------
  assign ld_addr32 = 32'(in_texel_address);
  assign mem_we = in_xfer && (in_action == twcd_pkg::ACT_LOAD)
               && (ld_addr32 < 32'(STORE_DEPTH));

  // Clamp the texture row to the texture height
  always_comb begin
    if (pos_r[PW-1]) begin
      trow = '0;
    end else if (pos_r[PW-1:16] >= (PW-16)'(TEX_SIZE)) begin
      trow = TW'(TEX_SIZE - 1);
    end else begin
      trow = pos_r[16 +: TW];
    end
  end

  assign rd_addr32 = 32'(choice_r) * 32'(TEX_SIZE * TEX_SIZE)
                   + 32'(trow) * 32'(TEX_SIZE) + 32'(texcol_r);

  twcd_tex_mem #(.DEPTH(STORE_DEPTH), .AW(SAW)) u_tex_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ld_addr32[SAW-1:0]),
    .wdata (in_texel_color),
    .re    (mem_re),
    .raddr (rd_addr32[SAW-1:0]),
    .rdata (mem_rdata)
  );

  assign shaded = shade_r ? ({1'b0, mem_rdata[CLW-1:1]} & twcd_pkg::HALF_MASK) : mem_rdata;

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt       = cnt_r;
    height_nxt    = height_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    mcand_nxt     = mcand_r;
    pos_nxt       = pos_r;
    choice_nxt    = choice_r;
    shade_nxt     = shade_r;
    texcol_nxt    = texcol_r;
    cur_row_nxt   = cur_row_r;
    stop_row_nxt  = stop_row_r;
    col_latch_nxt = col_latch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_color_nxt = out_color_r;
    out_write_nxt = out_write_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      twcd_pkg::ST_IDLE: begin
        if (in_xfer && in_action == twcd_pkg::ACT_START) begin
          choice_nxt    = choice_sel;
          shade_nxt     = (choice_sel == twcd_pkg::TEX_NORTH)
                       || (choice_sel == twcd_pkg::TEX_EAST);
          texcol_nxt    = mirror ? (TW'(TEX_SIZE - 1) - col_clamped) : col_clamped;
          height_nxt    = height_eff;
          rem_nxt       = '0;
          step_nxt      = '0;
          pos_nxt       = '0;
          mcand_nxt     = {{(PW - twcd_pkg::OFF_W){offset[twcd_pkg::OFF_W-1]}}, offset};
          cnt_nxt       = '0;
          cur_row_nxt   = in_first_row;
          stop_row_nxt  = in_end_row;
          col_latch_nxt = in_screen_column;
        end
      end
      twcd_pkg::ST_DIV: begin
        rem_nxt  = div_ge ? alu_y[twcd_pkg::FRAC_W-1:0] : rem_sh[twcd_pkg::FRAC_W-1:0];
        step_nxt = {step_r[DW-2:0], div_ge};
        cnt_nxt  = cnt_done ? '0 : cnt_r + CW'(1);
      end
      twcd_pkg::ST_MUL: begin
        // Shift-add over the step bits, LSB first
        pos_nxt   = alu_y;
        mcand_nxt = mcand_r << 1;
        cnt_nxt   = cnt_done ? '0 : cnt_r + CW'(1);
      end
      twcd_pkg::ST_FETCH: begin
        pos_nxt = alu_y;
      end
      twcd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = cur_row_r;
          out_col_nxt   = col_latch_r;
          out_color_nxt = shaded;
          out_write_nxt = shaded != '0;
          out_last_nxt  = ({1'b0, cur_row_r} + (RW+1)'(1)) == {1'b0, stop_row_r};
          cur_row_nxt   = cur_row_r + RW'(1);
          // Row counter wrapped: close the slice
          if (cur_row_r == '1) stop_row_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twcd_pkg::ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      pos_r       <= '0;
      choice_r    <= '0;
      shade_r     <= 1'b0;
      texcol_r    <= '0;
      cur_row_r   <= '0;
      stop_row_r  <= '0;
      col_latch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      choice_r    <= choice_nxt;
      shade_r     <= shade_nxt;
      texcol_r    <= texcol_nxt;
      cur_row_r   <= cur_row_nxt;
      stop_row_r  <= stop_row_nxt;
      col_latch_r <= col_latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    height_r    <= height_nxt;
    rem_r       <= rem_nxt;
    mcand_r     <= mcand_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_color_r <= out_color_nxt;
    out_write_r <= out_write_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_row    = out_row_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_color  = out_color_r;
  assign out_write_pixel  = out_write_r;
  assign out_last_row     = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pixel_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == twcd_pkg::ST_EMIT))
    else $error("pixel loaded outside emit state");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_action == twcd_pkg::ACT_START) |=> (in_stall && state_r == twcd_pkg::ST_DIV))
    else $error("column start did not enter division");

  a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_write_r == (out_color_r != '0)))
    else $error("write flag does not match pixel color");

  a_shade_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twcd_pkg::ST_EMIT && out_free && shade_r)
      |=> ((out_color_r & ~twcd_pkg::HALF_MASK) == '0))
    else $error("shaded pixel has channel MSB set");

endmodule

/* dv/tb_textured_wall_column_drawer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_textured_wall_column_drawer
// Self-checking bench for the textured wall column drawer. The first and last
// texture column of every texture are loaded first, and every column start
// lands on one of them. Directed and random column slices are then drawn
// under random sender gaps and receiver stalls. A scoreboard predicts each
// pixel from the accepted commands and compares it field by field.
// ----------------------------------------------------------------------------
module tb_textured_wall_column_drawer;
  import twcd_pkg::*;

  localparam int TEX         = TEX_SIZE_DEF;
  localparam int SCREEN_H    = SCREEN_HEIGHT_DEF;
  localparam int STORE_DEPTH = TEXTURE_COUNT_DEF * TEX * TEX;
  localparam int RANDOM_ITEMS = 1050;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 60;
  // Fraction range that maps onto one texture column
  localparam int FRAC_SPAN   = 65536 / TEX;

  typedef struct {
    action_t               act;
    logic [ADDR_W-1:0]     addr;
    logic [COLOR_W-1:0]    color;
    logic [1:0]            kind;
    logic                  side;
    logic                  xneg;
    logic                  ypos;
    logic [FRAC_W-1:0]     frac;
    logic [FRAC_W-1:0]     height;
    logic [ROW_W-1:0]      first_row;
    logic [ROW_W-1:0]      end_row;
    logic [ROW_W-1:0]      column;
  } command_t;

  typedef struct {
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   column;
    logic [COLOR_W-1:0] color;
    logic               written;
    logic               last;
  } pixel_t;

  class pixel_scoreboard;
    logic [COLOR_W-1:0] texel_copy [STORE_DEPTH];
    tex_id_t            tex_sel;
    bit                 shade;
    int                 tex_col;
    int                 row_step;
    longint             tex_pos;
    logic [ROW_W-1:0]   cur_row;
    logic [ROW_W-1:0]   stop_row;
    logic [ROW_W-1:0]   col_x;
    pixel_t             expected_pixels [$];
    int errors = 0;
    int loads = 0;
    int starts = 0;
    int draws = 0;
    int pixels = 0;
    int blank_pixels = 0;

    function new();
      tex_sel  = TEX_NORTH;
      shade    = 1'b0;
      tex_col  = 0;
      row_step = 0;
      tex_pos  = 0;
      cur_row  = '0;
      stop_row = '0;
      col_x    = '0;
    endfunction

    function void setup_column(command_t c);
      int h;
      if (c.kind == HIT_DOOR) tex_sel = TEX_DOOR;
      else if (c.kind == HIT_OPEN) tex_sel = TEX_DOOR_OPEN;
      else if (!c.side) tex_sel = c.xneg ? TEX_WEST : TEX_EAST;
      else tex_sel = c.ypos ? TEX_SOUTH : TEX_NORTH;
      shade = (tex_sel == TEX_NORTH) || (tex_sel == TEX_EAST);
      tex_col = (int'(c.frac) * TEX) >> 16;
      if (tex_col > TEX - 1) tex_col = TEX - 1;
      if ((!c.side && c.xneg) || (c.side && c.ypos)) tex_col = TEX - 1 - tex_col;
      h = (c.height == 0) ? 1 : int'(c.height);
      row_step = (TEX << 16) / h;
      tex_pos = longint'(int'(c.first_row) - SCREEN_H / 2 + h / 2) * longint'(row_step);
      cur_row  = c.first_row;
      stop_row = c.end_row;
      col_x    = c.column;
    endfunction

    function void predict_pixel();
      int     trow;
      pixel_t p;
      if (cur_row >= stop_row) return;
      if (tex_pos < 0) trow = 0;
      else if ((tex_pos >>> 16) >= TEX) trow = TEX - 1;
      else trow = int'(tex_pos >>> 16);
      tex_pos += longint'(row_step);
      p.color = texel_copy[int'(tex_sel) * TEX * TEX + trow * TEX + tex_col];
      if (shade) p.color = (p.color >> 1) & HALF_MASK;
      p.row     = cur_row;
      p.column  = col_x;
      p.written = (p.color != 0);
      p.last    = (int'(cur_row) + 1 == int'(stop_row));
      expected_pixels.push_back(p);
      cur_row = cur_row + 1'b1;
      if (cur_row == 0) stop_row = '0;
    endfunction

    function void note_command(command_t c);
      case (c.act)
        ACT_LOAD: begin
          loads++;
          if (int'(c.addr) < STORE_DEPTH) texel_copy[c.addr] = c.color;
        end
        ACT_START: begin
          starts++;
          setup_column(c);
        end
        ACT_DRAW: begin
          draws++;
          predict_pixel();
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string field, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
      errors++;
      if (errors <= 50)
        $display("mismatch %0d at %0t: %s got %h want %h", errors, $time, field, got, want);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending, row", COLOR_W'(got.row), '0);
        return;
      end
      want = expected_pixels.pop_front();
      pixels++;
      if (!want.written) blank_pixels++;
      if (got.row !== want.row)
        report_mismatch("pixel_row", COLOR_W'(got.row), COLOR_W'(want.row));
      if (got.column !== want.column)
        report_mismatch("pixel_column", COLOR_W'(got.column), COLOR_W'(want.column));
      if (got.color !== want.color) report_mismatch("pixel_color", got.color, want.color);
      if (got.written !== want.written)
        report_mismatch("write_pixel", COLOR_W'(got.written), COLOR_W'(want.written));
      if (got.last !== want.last)
        report_mismatch("last_row", COLOR_W'(got.last), COLOR_W'(want.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_action = ACT_NONE;
  logic [ADDR_W-1:0]   in_texel_address = '0;
  logic [COLOR_W-1:0]  in_texel_color = '0;
  logic [1:0]          in_hit_kind = HIT_WALL;
  logic                in_hit_vertical_side = 1'b0;
  logic                in_dir_x_negative = 1'b0;
  logic                in_dir_y_positive = 1'b0;
  logic [FRAC_W-1:0]   in_wall_fraction = '0;
  logic [FRAC_W-1:0]   in_wall_line_height = '0;
  logic [ROW_W-1:0]    in_first_row = '0;
  logic [ROW_W-1:0]    in_end_row = '0;
  logic [ROW_W-1:0]    in_screen_column = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROW_W-1:0]    out_pixel_row;
  logic [ROW_W-1:0]    out_pixel_column;
  logic [COLOR_W-1:0]  out_pixel_color;
  logic                out_write_pixel;
  logic                out_last_row;

  pixel_scoreboard sb = new();
  bit  idle_on = 1'b1;
  int  burst_left = 0;
  int  items_sent = 0;
  bit  hold_req = 1'b0;

  textured_wall_column_drawer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_texel_address     (in_texel_address),
    .in_texel_color       (in_texel_color),
    .in_hit_kind          (in_hit_kind),
    .in_hit_vertical_side (in_hit_vertical_side),
    .in_dir_x_negative    (in_dir_x_negative),
    .in_dir_y_positive    (in_dir_y_positive),
    .in_wall_fraction     (in_wall_fraction),
    .in_wall_line_height  (in_wall_line_height),
    .in_first_row         (in_first_row),
    .in_end_row           (in_end_row),
    .in_screen_column     (in_screen_column),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pixel_row        (out_pixel_row),
    .out_pixel_column     (out_pixel_column),
    .out_pixel_color      (out_pixel_color),
    .out_write_pixel      (out_write_pixel),
    .out_last_row         (out_last_row)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch both channels; values read here are the ones present at the edge.
  always @(posedge clk) begin : monitor
    command_t taken;
    pixel_t   seen;
    if (rst_n && in_valid && !in_stall) begin
      taken.act       = action_t'(in_action);
      taken.addr      = in_texel_address;
      taken.color     = in_texel_color;
      taken.kind      = in_hit_kind;
      taken.side      = in_hit_vertical_side;
      taken.xneg      = in_dir_x_negative;
      taken.ypos      = in_dir_y_positive;
      taken.frac      = in_wall_fraction;
      taken.height    = in_wall_line_height;
      taken.first_row = in_first_row;
      taken.end_row   = in_end_row;
      taken.column    = in_screen_column;
      sb.note_command(taken);
    end
    if (rst_n && out_valid && !out_stall) begin
      seen.row     = out_pixel_row;
      seen.column  = out_pixel_column;
      seen.color   = out_pixel_color;
      seen.written = out_write_pixel;
      seen.last    = out_last_row;
      sb.check_pixel(seen);
    end
  end

  // Receiver: stall patterns over random segments, plus a long hold on request.
  initial begin : receiver
    int hold_left;
    int seg_left;
    int pattern;
    bit stall_now;
    hold_left = 0;
    seg_left  = 0;
    pattern   = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(64, 1);
          pattern  = $urandom_range(3, 0);
        end
        seg_left--;
        case (pattern)
          0: stall_now = 1'b0;
          1: stall_now = ($urandom_range(3, 0) == 0);
          2: stall_now = ($urandom_range(3, 0) != 0);
          default: stall_now = !stall_now;
        endcase
      end
      out_stall <= stall_now;
    end
  end

  initial begin
    #3_000_000;
    $display("[textured_wall_column_drawer] ERROR");
    $finish;
  end

  // Wall fraction that lands on the first or last texture column.
  function automatic logic [FRAC_W-1:0] loaded_column_frac();
    if ($urandom_range(1, 0) == 0) return FRAC_W'($urandom_range(FRAC_SPAN - 1, 0));
    return FRAC_W'($urandom_range(65535, 65536 - FRAC_SPAN));
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.act       = action_t'($urandom_range(3, 0));
    c.addr      = ADDR_W'($urandom_range(STORE_DEPTH - 1, 0));
    c.color     = COLOR_W'($urandom);
    c.kind      = 2'($urandom_range(3, 0));
    c.side      = 1'($urandom_range(1, 0));
    c.xneg      = 1'($urandom_range(1, 0));
    c.ypos      = 1'($urandom_range(1, 0));
    c.frac      = loaded_column_frac();
    c.height    = FRAC_W'($urandom);
    c.first_row = ROW_W'($urandom);
    c.end_row   = ROW_W'($urandom);
    c.column    = ROW_W'($urandom);
    return c;
  endfunction

  // Present one command and hold it until the transfer happens.
  task automatic send(input command_t c);
    int gap;
    if (idle_on && burst_left <= 0) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? 150 : $urandom_range(16, 1);
    end
    in_valid             <= 1'b1;
    in_action            <= c.act;
    in_texel_address     <= c.addr;
    in_texel_color       <= c.color;
    in_hit_kind          <= c.kind;
    in_hit_vertical_side <= c.side;
    in_dir_x_negative    <= c.xneg;
    in_dir_y_positive    <= c.ypos;
    in_wall_fraction     <= c.frac;
    in_wall_line_height  <= c.height;
    in_first_row         <= c.first_row;
    in_end_row           <= c.end_row;
    in_screen_column     <= c.column;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_action(input action_t act);
    command_t c;
    c = random_command();
    c.act = act;
    send(c);
  endtask

  // Stop offering and wait for every pending pixel.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic run_column(input logic [1:0] kind, input bit side, input bit xneg,
                            input bit ypos, input logic [FRAC_W-1:0] frac,
                            input logic [FRAC_W-1:0] height,
                            input logic [ROW_W-1:0] top, input logic [ROW_W-1:0] stop,
                            input logic [ROW_W-1:0] column, input int draws);
    command_t c;
    c = random_command();
    c.act       = ACT_START;
    c.kind      = kind;
    c.side      = side;
    c.xneg      = xneg;
    c.ypos      = ypos;
    c.frac      = frac;
    c.height    = height;
    c.first_row = top;
    c.end_row   = stop;
    c.column    = column;
    send(c);
    repeat (draws) send_action(ACT_DRAW);
  endtask

  // Load the first and last column of every texture, all rows.
  task automatic preload_textures();
    command_t c;
    int t;
    int r;
    int k;
    idle_on = 1'b0;
    for (t = 0; t < TEXTURE_COUNT_DEF; t++) begin
      for (r = 0; r < TEX; r++) begin
        for (k = 0; k < 2; k++) begin
          c = random_command();
          c.act  = ACT_LOAD;
          c.addr = ADDR_W'(t * TEX * TEX + r * TEX + k * (TEX - 1));
          case ($urandom_range(15, 0))
            0: c.color = '0;
            1: c.color = 24'h000001;
            2: c.color = 24'hFFFFFF;
            default: ;
          endcase
          send(c);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic random_load();
    command_t c;
    c = random_command();
    c.act = ACT_LOAD;
    if ($urandom_range(7, 0) == 0) c.addr = ADDR_W'($urandom_range(32767, STORE_DEPTH));
    if ($urandom_range(7, 0) == 0) c.color = '0;
    send(c);
  endtask

  // Column as a raycaster would issue it, with loads and noise mixed in.
  task automatic well_formed_column();
    command_t c;
    int h;
    int top;
    int bottom;
    int span;
    int draws;
    h = ($urandom_range(7, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(900, 1);
    top = SCREEN_H / 2 - h / 2;
    if (top < 0) top = 0;
    bottom = SCREEN_H / 2 + h / 2;
    if (bottom > SCREEN_H) bottom = SCREEN_H;
    span = ($urandom_range(19, 0) == 0) ? $urandom_range(120, 0) : $urandom_range(24, 0);
    if ($urandom_range(9, 0) == 0) begin
      top = $urandom_range(4095, 0);
      bottom = top + span;
      if (bottom > 4095) bottom = 4095;
    end else if (bottom > top) begin
      top = $urandom_range(bottom - 1, top);
      if (top + span < bottom) bottom = top + span;
    end
    c = random_command();
    c.act       = ACT_START;
    c.kind      = ($urandom_range(5, 0) == 0) ? 2'($urandom_range(3, 1)) : HIT_WALL;
    c.height    = h[FRAC_W-1:0];
    c.first_row = top[ROW_W-1:0];
    c.end_row   = bottom[ROW_W-1:0];
    send(c);
    draws = ((bottom > top) ? bottom - top : 0) + $urandom_range(2, 0);
    repeat (draws) begin
      if ($urandom_range(11, 0) == 0) random_load();
      if ($urandom_range(29, 0) == 0) send_action(ACT_NONE);
      send_action(ACT_DRAW);
    end
  endtask

  // Long receiver hold while draws keep coming, then pause until all arrive.
  task automatic fill_under_hold();
    drain();
    hold_req = 1'b1;
    run_column(HIT_WALL, 1'b1, 1'b0, 1'b1, loaded_column_frac(), 16'd64, 12'd200, 12'd260,
               ROW_W'($urandom), 60);
    drain();
  endtask

  initial begin
    int random_goal;
    int pick;
    int pressure_done;
    pressure_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Draw before any column start, and an ACT_NONE command: no pixel either way.
    send_action(ACT_DRAW);
    send_action(ACT_NONE);
    preload_textures();

    // Loads outside the store must be dropped.
    begin : directed_loads
      command_t c;
      c = random_command();
      c.act = ACT_LOAD;
      c.addr = ADDR_W'(STORE_DEPTH);
      c.color = 24'hFFFFFF;
      send(c);
      c.addr = '1;
      send(c);
    end
    run_column(HIT_WALL, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd64, 12'd208, 12'd211, 12'd0, 2);
    run_column(HIT_WALL, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'd1, 12'd239, 12'd241, 12'd4095, 2);
    run_column(HIT_WALL, 1'b1, 1'b0, 1'b0, 16'h03FF, 16'hFFFF, 12'd0, 12'd2, 12'd17, 2);
    run_column(HIT_WALL, 1'b1, 1'b0, 1'b1, 16'hFC00, 16'd0, 12'd240, 12'd241, 12'd33, 2);
    run_column(HIT_DOOR, 1'b0, 1'b1, 1'b0, 16'h0123, 16'd128, 12'd176, 12'd178, 12'd5, 1);
    run_column(HIT_OPEN, 1'b1, 1'b0, 1'b1, 16'hFFF0, 16'd300, 12'd100, 12'd102, 12'd6, 1);
    run_column(2'd3, 1'b1, 1'b0, 1'b0, 16'h0200, 16'd480, 12'd0, 12'd1, 12'd7, 1);
    run_column(HIT_WALL, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'd20, 12'd4093, 12'd4095, 12'd8, 2);
    run_column(HIT_WALL, 1'b1, 1'b1, 1'b1, 16'h0001, 16'd50, 12'd4095, 12'd0, 12'd9, 1);
    drain();

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      if (pressure_done < 2 && items_sent >= random_goal - RANDOM_ITEMS * (2 - pressure_done) / 3)
      begin
        fill_under_hold();
        pressure_done++;
      end
      pick = $urandom_range(9, 0);
      if (pick < 8) begin
        well_formed_column();
      end else begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(1, 0) == 0) random_load();
          else send(random_command());
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d texel loads, %0d column starts and %0d row draws",
             sb.loads, sb.starts, sb.draws);
    $display("%0d pixels compared, %0d of them flagged as not written",
             sb.pixels, sb.blank_pixels);
    if (sb.errors == 0) begin
      $display("[textured_wall_column_drawer] OK");
    end else begin
      $display("[textured_wall_column_drawer] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/twcd_pkg.sv
hdl/twcd_alu.sv
hdl/twcd_tex_mem.sv
hdl/textured_wall_column_drawer.sv
dv/tb_textured_wall_column_drawer.sv
